/* rtl/cpc_pkg.sv */
// Shared types and constants for the circle pair collision pipeline.
`default_nettype none
package cpc_pkg;
  localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;
  localparam int OUT_W = 36;

  // payload passed from the front stage into the CORDIC stages
  typedef struct packed {
    logic        is_zero;
    logic        flip;
    logic [32:0] rsum;
    logic [31:0] rdif;
  } cpc_side_t;
endpackage
`default_nettype wire

/* rtl/cpc_gain_mult.sv */
// Two-stage floor(a * GAIN_INV / 2^32) for a nonnegative 64-bit value.
`default_nettype none
module cpc_gain_mult (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  output logic      [63:0] p
);
  import cpc_pkg::*;
  logic [63:0] hi_prod;
  logic [63:0] lo_prod;

  // form the two 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hi_prod <= a[63:32] * GAIN_INV;
      lo_prod <= a[31:0] * GAIN_INV;
    end
  end

  // combine the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p <= hi_prod + {32'd0, lo_prod[63:32]};
    end
  end
endmodule
`default_nettype wire

/* rtl/circle_pair_collision.sv */
// Top level of the circle pair collision pipeline.
//
// Fully pipelined circle pair test: one pair is accepted in every cycle
// that the pipe is not stalled, and each result passes in order through
// the front difference stage, one register stage per vectoring step,
// two stages for each gain correction multiplier, the flag stage, one
// register stage per rotation step and the output register. All stages
// advance together when the output is free or empty, so a stall freezes the
// whole pipe and loses nothing.
`default_nettype none
module circle_pair_collision #(
  parameter int CORDIC_STEPS  = 24,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] a_center_x,
  input  wire logic signed [31:0] a_center_y,
  input  wire logic        [30:0] a_radius,
  input  wire logic signed [31:0] b_center_x,
  input  wire logic signed [31:0] b_center_y,
  input  wire logic        [30:0] b_radius,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [35:0]      push_x,
  output logic signed [35:0]      push_y,
  output logic                    overlap,
  output logic                    contained
);
  import cpc_pkg::*;
  localparam int N = CORDIC_STEPS;
  localparam int LAT = 2 * N + 6;
  localparam logic signed [63:0] OMAX = 64'sd34359738367;
  localparam logic signed [63:0] OMIN = -64'sd34359738368;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  // advance valid bits along the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
      out_valid <= vld[LAT-1];
    end
  end

  // front stage: difference, half plane fold, radii
  logic signed [63:0] x0, y0;
  cpc_side_t side0;
  always_ff @(posedge clk) begin
    logic signed [32:0] vx, vy;
    vx = 33'(b_center_x) - 33'(a_center_x);
    vy = 33'(b_center_y) - 33'(a_center_y);
    if (en) begin
      side0.is_zero <= (vx == 0) && (vy == 0);
      side0.flip <= vx < 0;
      side0.rsum <= {2'b0, a_radius} + {2'b0, b_radius};
      side0.rdif <= (a_radius > b_radius) ? {1'b0, a_radius - b_radius}
                                          : {1'b0, b_radius - a_radius};
      x0 <= (vx < 0 ? -64'(vx) : 64'(vx)) <<< FRACTION_BITS;
      y0 <= (vx < 0 ? -64'(vy) : 64'(vy)) <<< FRACTION_BITS;
    end
  end

  // vectoring stages
  logic signed [63:0] vxs [N+1];
  logic signed [63:0] vys [N+1];
  logic [N-1:0] dirs [N+1];
  cpc_side_t vside [N+1];
  assign vxs[0] = x0;
  assign vys[0] = y0;
  assign dirs[0] = '0;
  assign vside[0] = side0;
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      logic d;
      d = vys[i] > 0;
      if (en) begin
        vxs[i+1] <= d ? vxs[i] + (vys[i] >>> i) : vxs[i] - (vys[i] >>> i);
        vys[i+1] <= d ? vys[i] - (vxs[i] >>> i) : vys[i] + (vxs[i] >>> i);
        dirs[i+1] <= dirs[i] | (N'(d) << i);
        vside[i+1] <= vside[i];
      end
    end
  end

  // distance gain correction
  logic [63:0] dist_mag;
  logic [N-1:0] dir_d1, dir_d2;
  cpc_side_t side_d1, side_d2;
  cpc_gain_mult u_dist (
    .clk(clk), .en(en),
    .a(vxs[N] < 0 ? 64'd0 : 64'(vxs[N])), .p(dist_mag)
  );
  always_ff @(posedge clk) begin
    if (en) begin
      dir_d1 <= dirs[N];
      dir_d2 <= dir_d1;
      side_d1 <= vside[N];
      side_d2 <= side_d1;
    end
  end

  // flags and translation magnitude
  logic [63:0] tmag;
  logic ov_f, ct_f;
  logic [N-1:0] dir_f;
  cpc_side_t side_f;
  always_ff @(posedge clk) begin
    logic signed [63:0] rs, rd, t;
    rs = 64'(side_d2.rsum) <<< FRACTION_BITS;
    rd = 64'(side_d2.rdif) <<< FRACTION_BITS;
    t = rs - $signed(dist_mag);
    if (en) begin
      tmag <= t < 0 ? 64'(-t) : 64'(t);
      ov_f <= $signed(dist_mag) < rs;
      ct_f <= $signed(dist_mag) <= rd;
      dir_f <= dir_d2;
      side_f <= side_d2;
    end
  end

  // rotation gain correction
  logic [63:0] rmag;
  logic ov_g1, ov_g2, ct_g1, ct_g2;
  logic [N-1:0] dir_g1, dir_g2;
  cpc_side_t side_g1, side_g2;
  cpc_gain_mult u_rot (.clk(clk), .en(en), .a(tmag), .p(rmag));
  always_ff @(posedge clk) begin
    if (en) begin
      {ov_g1, ct_g1, dir_g1, side_g1} <= {ov_f, ct_f, dir_f, side_f};
      {ov_g2, ct_g2, dir_g2, side_g2} <= {ov_g1, ct_g1, dir_g1, side_g1};
    end
  end

  // rotation stages
  logic signed [63:0] rxs [N+1];
  logic signed [63:0] rys [N+1];
  logic [N-1:0] rdir [N+1];
  logic rov [N+1];
  logic rct [N+1];
  cpc_side_t rside [N+1];
  assign rxs[0] = $signed(rmag);
  assign rys[0] = '0;
  assign rdir[0] = dir_g2;
  assign rov[0] = ov_g2;
  assign rct[0] = ct_g2;
  assign rside[0] = side_g2;
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        rxs[i+1] <= rdir[i][i] ? rxs[i] - (rys[i] >>> i) : rxs[i] + (rys[i] >>> i);
        rys[i+1] <= rdir[i][i] ? rys[i] + (rxs[i] >>> i) : rys[i] - (rxs[i] >>> i);
        rdir[i+1] <= rdir[i];
        rov[i+1] <= rov[i];
        rct[i+1] <= rct[i];
        rside[i+1] <= rside[i];
      end
    end
  end

  // output rounding, saturation and the zero distance case
  function automatic logic signed [35:0] to_out(input logic signed [63:0] c);
    logic signed [63:0] r;
    r = (c + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    if (r > OMAX) r = OMAX;
    if (r < OMIN) r = OMIN;
    return r[35:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [63:0] px, py;
    px = rside[N].flip ? -rxs[N] : rxs[N];
    py = rside[N].flip ? -rys[N] : rys[N];
    if (en) begin
      if (rside[N].is_zero) begin
        push_x <= 36'(rside[N].rsum);
        push_y <= '0;
        overlap <= rside[N].rsum != 0;
        contained <= 1'b1;
      end else begin
        push_x <= to_out(px);
        push_y <= to_out(py);
        overlap <= rov[N];
        contained <= rct[N];
      end
    end
  end

  // a result appears only where an item was in the last stage
  assert property (@(posedge clk) disable iff (rst)
    en |=> (out_valid == $past(vld[LAT-1])))
    else $error("output valid out of step with pipe");
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("stall without a waiting result");
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved during stall");
endmodule
`default_nettype wire

/* verif/circle_pair_collision_tb.sv */
// Self-checking testbench for the circle pair collision pipeline.
`default_nettype none
module circle_pair_collision_tb;
  localparam int STEPS = 24;
  localparam int FRAC = 16;
  localparam int LATENCY = 2 * STEPS + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] GAIN_FIX = 64'h9B74EDA8;
  localparam longint PUSH_MAX = 64'sd34359738367;
  localparam longint PUSH_MIN = -64'sd34359738368;

  typedef struct packed {
    logic signed [35:0] px;
    logic signed [35:0] py;
    logic               ovl;
    logic               cont;
  } push_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] a_center_x;
  logic signed [31:0] a_center_y;
  logic [30:0] a_radius;
  logic signed [31:0] b_center_x;
  logic signed [31:0] b_center_y;
  logic [30:0] b_radius;
  logic out_valid;
  logic out_stall;
  logic signed [35:0] push_x;
  logic signed [35:0] push_y;
  logic overlap;
  logic contained;

  push_t pending_push[$];
  int err_count;
  int cycle_count;
  bit stall_mode;

  circle_pair_collision u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .a_center_x(a_center_x), .a_center_y(a_center_y), .a_radius(a_radius),
    .b_center_x(b_center_x), .b_center_y(b_center_y), .b_radius(b_radius),
    .out_valid(out_valid), .out_stall(out_stall), .push_x(push_x),
    .push_y(push_y), .overlap(overlap), .contained(contained)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor(a * 1/K) for nonnegative a
  function automatic longint unscale_gain(longint a);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = 64'(a) >> 32;
    lo = 64'(a) & 64'hFFFFFFFF;
    return longint'(hi * GAIN_FIX + ((lo * GAIN_FIX) >> 32));
  endfunction

  function automatic logic signed [35:0] round_push(longint c);
    longint r;
    r = (c + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (r > PUSH_MAX) r = PUSH_MAX;
    if (r < PUSH_MIN) r = PUSH_MIN;
    return r[35:0];
  endfunction

  function automatic push_t predict_push(logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic [30:0] ar, logic signed [31:0] bx,
                                         logic signed [31:0] by, logic [30:0] br);
    longint vx, vy, rsum, rdif, x, y, dx, dy, sep, t;
    bit flip;
    bit turn[STEPS];
    push_t p;
    vx = longint'(bx) - longint'(ax);
    vy = longint'(by) - longint'(ay);
    rsum = longint'(ar) + longint'(br);
    rdif = ar > br ? longint'(ar) - longint'(br) : longint'(br) - longint'(ar);
    flip = 1'b0;
    // coincident centres push along +x
    if (vx == 0 && vy == 0) begin
      p.px = rsum[35:0];
      p.py = '0;
      p.ovl = rsum > 0;
      p.cont = 1'b1;
      return p;
    end
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      flip = 1'b1;
    end
    x = vx <<< FRAC;
    y = vy <<< FRAC;
    // vector onto the x axis, record the turn directions
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      turn[i] = y > 0;
      if (turn[i]) begin
        x += dx;
        y -= dy;
      end else begin
        x -= dx;
        y += dy;
      end
    end
    sep = unscale_gain(x < 0 ? 0 : x);
    t = (rsum <<< FRAC) - sep;
    if (t < 0) t = -t;
    x = unscale_gain(t);
    y = 0;
    // rotate the push length back along v
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (turn[i]) begin
        x -= dx;
        y += dy;
      end else begin
        x += dx;
        y -= dy;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    p.px = round_push(x);
    p.py = round_push(y);
    p.ovl = sep < (rsum <<< FRAC);
    p.cont = sep <= (rdif <<< FRAC);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Drive one beat and hold it until accepted; then a gap of the given length.
  task automatic send_pair(logic signed [31:0] ax, logic signed [31:0] ay, logic [30:0] ar,
                           logic signed [31:0] bx, logic signed [31:0] by, logic [30:0] br,
                           int gap);
    a_center_x <= ax;
    a_center_y <= ay;
    a_radius <= ar;
    b_center_x <= bx;
    b_center_y <= by;
    b_radius <= br;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_push.push_back(predict_push(ax, ay, ar, bx, by, br));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 1000)) << 16;
      2: return $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0;
      default: return 31'($urandom_range(0, 65535)) << $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(0, 0, 31'd0, 0, 0, 31'd0, 0);
    send_pair(5 <<< 16, -3 <<< 16, 31'(2 <<< 16), 5 <<< 16, -3 <<< 16, 31'(1 <<< 16), 1);
    send_pair(0, 0, 31'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 0);
    send_pair(0, 0, 31'(1 <<< 16), 3 <<< 16, 0, 31'(1 <<< 16), 0);
    send_pair(0, 0, 31'(1 <<< 16), 2 <<< 16, 0, 31'(1 <<< 16), 2);
    send_pair(0, 0, 31'(10 <<< 16), 1 <<< 16, 1 <<< 16, 31'(2 <<< 16), 0);
    send_pair(4 <<< 16, 0, 31'(1 <<< 16), 0, 0, 31'(1 <<< 16), 0);
    send_pair(0, 4 <<< 16, 31'(1 <<< 16), 0, 0, 31'(1 <<< 16), 0);
    send_pair(0, 0, 31'(1 <<< 16), 0, 4 <<< 16, 31'(1 <<< 16), 0);
    send_pair(0, 0, 31'd0, -3 <<< 16, -4 <<< 16, 31'd0, 3);
    send_pair(32'h80000000, 32'h80000000, 31'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 0);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 31'd0, 32'h80000000, 32'h80000000, 31'd0, 0);
    send_pair(32'h7FFFFFFF, 32'h80000000, 31'd1, 32'h80000000, 32'h7FFFFFFF,
              31'h7FFFFFFF, 0);
    send_pair(0, 0, 31'd0, 1, 0, 31'd0, 0);
    send_pair(0, 0, 31'd0, 0, -1, 31'd0, 0);
    send_pair(-1, 0, 31'd0, 0, 0, 31'd0, 0);
    send_pair(32'h55555555, 32'hAAAAAAAA, 31'h55555555,
              32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA, 0);
    idle_sender();
  endtask

  task automatic test_random(int n);
    int burst;
    int gap;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n > 0; k++, n--) begin
        gap = (k == burst - 1) ? $urandom_range(1, 12) : 0;
        send_pair(rand_coord(), rand_coord(), rand_radius(),
                  rand_coord(), rand_coord(), rand_radius(), gap);
      end
    end
    idle_sender();
  endtask

  // Hold off until the pipe has returned every expectation, then send five pairs.
  task automatic test_drain_pause();
    while (pending_push.size() != 0) @(negedge clk);
    repeat (5) send_pair(rand_coord(), rand_coord(), rand_radius(),
                         rand_coord(), rand_coord(), rand_radius(), 0);
    idle_sender();
  endtask

  // Receiver stall pattern: long free runs, heavy stall stretches, random.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 15) == 0);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    push_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_push.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_push.pop_front();
        if (push_x !== want.px) report_mismatch("push_x", push_x, want.px);
        if (push_y !== want.py) report_mismatch("push_y", push_y, want.py);
        if (overlap !== want.ovl) report_mismatch("overlap", overlap, want.ovl);
        if (contained !== want.cont) report_mismatch("contained", contained, want.cont);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    err_count = 0;
    cycle_count = 0;
    stall_mode = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    a_center_x = '0;
    a_center_y = '0;
    a_radius = '0;
    b_center_x = '0;
    b_center_y = '0;
    b_radius = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(600);
    test_drain_pause();
    test_random(600);
    while (pending_push.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
